### design/pte_pkg.sv
`timescale 1ns / 1ps

package pte_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCountBits = $clog2(QueueDepth + 1);

   localparam logic [2:0] HeaderLen = 3'd5;

   localparam logic [7:0] CH_PERCENT   = 8'h25;
   localparam logic [7:0] CH_P         = 8'h50;
   localparam logic [7:0] CH_D         = 8'h44;
   localparam logic [7:0] CH_F         = 8'h46;
   localparam logic [7:0] CH_DASH      = 8'h2D;
   localparam logic [7:0] CH_B         = 8'h42;
   localparam logic [7:0] CH_T         = 8'h54;
   localparam logic [7:0] CH_E         = 8'h45;
   localparam logic [7:0] CH_LPAREN    = 8'h28;
   localparam logic [7:0] CH_RPAREN    = 8'h29;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam int SlotText0 = 0;
   localparam int SlotText1 = 1;
   localparam int SlotDone  = 2;

   // results caused by one request: two text slots and the done slot
   typedef struct packed {
      logic [2:0] slot_valid;
      logic [7:0] text0;
      logic [7:0] text1;
      logic       status;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic [7:0] hdr_byte(logic [2:0] k);
      logic [7:0] r;
      case (k)
         3'd0: r = CH_PERCENT;
         3'd1: r = CH_P;
         3'd2: r = CH_D;
         3'd3: r = CH_F;
         3'd4: r = CH_DASH;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

### design/pdf_text_operator_extractor.sv
`timescale 1ns / 1ps

// Streams a PDF file one byte per request (req_last_byte on the final byte) and
// returns the text found in parenthesised strings inside BT/ET blocks, then one
// done response carrying the header status (0 when the file starts with "%PDF-").
// A request is taken every cycle unless req_stall is high; each byte decides the
// byte two places back, so text lags by two bytes; the last byte also decides
// the byte one back. One request yields zero to three responses, which leave
// one per cycle from an output register while rsp_stall is low. A four-entry
// queue of per-request response groups sits between the classifier and the
// output stage; req_stall rises only when that queue is full, so with rsp_stall
// low one byte per cycle is sustained if responses average at most one per byte.
module pdf_text_operator_extractor import pte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_done_res,
   output logic       rsp_header_status
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   bundle_type       push_data;
   bundle_type       head_data;

   pte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   pte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   pte_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_data         (head_data),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_text_byte     (rsp_text_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_done_res      (rsp_done_res),
      .rsp_header_status (rsp_header_status)
   );

endmodule

### design/pte_front.sv
`timescale 1ns / 1ps

module pte_front import pte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_last_byte,
   input  queue_status_type q_status,
   output logic             push,
   output bundle_type       push_data
);

   typedef struct packed {
      logic in_bt;
      logic in_string;
      logic skip_next;
      logic output_nonempty;
      logic output_ends_newline;
   } text_state_type;

   typedef struct packed {
      text_state_type st;
      logic           emit;
      logic [7:0]     ch;
   } dec_result_type;

   function automatic dec_result_type decide(text_state_type st, logic [7:0] prev,
                                             logic has_prev, logic [7:0] cur,
                                             logic [7:0] nxt, logic [7:0] nxt2,
                                             logic has_nxt2);
      dec_result_type r;
      logic left;
      logic right;
      logic guarded;
      r.st = st;
      r.emit = 1'b0;
      r.ch = 8'h00;
      left = !has_prev || is_ws(prev);
      right = !has_nxt2 || is_ws(nxt2);
      guarded = has_prev && (prev == CH_BACKSLASH);
      if (st.skip_next) begin
         r.st.skip_next = 1'b0;
      end else if ((nxt == CH_T) && left && right && ((cur == CH_B) || (cur == CH_E))) begin
         r.st.in_bt = (cur == CH_B);
         r.st.skip_next = 1'b1;
      end else if (st.in_bt) begin
         if ((cur == CH_LPAREN) && !guarded) begin
            r.st.in_string = 1'b1;
         end else if ((cur == CH_RPAREN) && !guarded) begin
            r.st.in_string = 1'b0;
            if (st.output_nonempty && !st.output_ends_newline) begin
               r.emit = 1'b1;
               r.ch = CH_SPACE;
            end
         end else if (st.in_string) begin
            r.emit = 1'b1;
            if (cur == CH_BACKSLASH) begin
               r.st.skip_next = 1'b1;
               if (nxt == CH_LOWER_N) begin
                  r.ch = CH_LF;
               end else if (nxt == CH_LOWER_R) begin
                  r.ch = CH_CR;
               end else if (nxt == CH_LOWER_T) begin
                  r.ch = CH_TAB;
               end else begin
                  r.ch = nxt;
               end
            end else begin
               r.ch = cur;
            end
         end
      end
      if (r.emit) begin
         r.st.output_nonempty = 1'b1;
         r.st.output_ends_newline = (r.ch == CH_LF);
      end
      return r;
   endfunction

   logic [7:0]     win0_ff, win1_ff, win2_ff;
   logic [7:0]     win0_in, win1_in, win2_in;
   logic [2:0]     seen_ff, seen_in;
   logic           hdr_good_ff, hdr_good_in;
   text_state_type st_ff, st_in;

   logic           accept;
   logic           hg;
   dec_result_type d1, d2;
   logic [2:0]     seen_next;

   assign req_stall = q_status.full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      hg = hdr_good_ff && !((seen_ff < HeaderLen) && (req_in_byte != hdr_byte(seen_ff)));
      if (seen_ff >= 3'd2) begin
         d1 = decide(st_ff, win2_ff, seen_ff >= 3'd3, win1_ff, win0_ff, req_in_byte, 1'b1);
      end else begin
         d1 = '{st: st_ff, emit: 1'b0, ch: 8'h00};
      end
      if (req_last_byte && (seen_ff >= 3'd1)) begin
         d2 = decide(d1.st, win1_ff, seen_ff >= 3'd2, win0_ff, req_in_byte, 8'h00, 1'b0);
      end else begin
         d2 = '{st: d1.st, emit: 1'b0, ch: 8'h00};
      end
      seen_next = (seen_ff < HeaderLen) ? seen_ff + 3'd1 : HeaderLen;

      push_data.slot_valid[SlotText0] = d1.emit && hg;
      push_data.slot_valid[SlotText1] = d2.emit && hg;
      push_data.slot_valid[SlotDone] = req_last_byte;
      push_data.text0 = d1.ch;
      push_data.text1 = d2.ch;
      push_data.status = !(hg && (seen_next >= HeaderLen));
      push = accept && (push_data.slot_valid != 3'b000);

      win0_in = win0_ff;
      win1_in = win1_ff;
      win2_in = win2_ff;
      seen_in = seen_ff;
      hdr_good_in = hdr_good_ff;
      st_in = st_ff;
      if (accept) begin
         if (req_last_byte) begin
            win0_in = 8'h00;
            win1_in = 8'h00;
            win2_in = 8'h00;
            seen_in = 3'd0;
            hdr_good_in = 1'b1;
            st_in = '0;
         end else begin
            win0_in = req_in_byte;
            win1_in = win0_ff;
            win2_in = win1_ff;
            seen_in = seen_next;
            hdr_good_in = hg;
            st_in = d2.st;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= 8'h00;
         win1_ff <= 8'h00;
         win2_ff <= 8'h00;
         seen_ff <= 3'd0;
         hdr_good_ff <= 1'b1;
         st_ff <= '0;
      end else begin
         win0_ff <= win0_in;
         win1_ff <= win1_in;
         win2_ff <= win2_in;
         seen_ff <= seen_in;
         hdr_good_ff <= hdr_good_in;
         st_ff <= st_in;
      end
   end

endmodule

### design/pte_queue.sv
`timescale 1ns / 1ps

module pte_queue import pte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bundle_type       push_data,
   input  logic             pop,
   output bundle_type       head_data,
   output queue_status_type q_status
);

   bundle_type                mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCountBits-1:0] count_ff, count_in;

   assign q_status.full = (count_ff == QueueCountBits'(QueueDepth));
   assign q_status.empty = (count_ff == '0);
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QueuePtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QueuePtrBits'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QueueCountBits'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QueueCountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/pte_back.sv
`timescale 1ns / 1ps

module pte_back import pte_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bundle_type       head_data,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_text_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_done_res,
   output logic             rsp_header_status
);

   logic [2:0] slots_ff, slots_in;
   logic [7:0] text0_ff, text0_in;
   logic [7:0] text1_ff, text1_in;
   logic       status_ff, status_in;

   logic [2:0] pick;
   logic [2:0] remaining;
   logic       take;

   always_comb begin
      pick = slots_ff & (~slots_ff + 3'd1);
      rsp_valid = (slots_ff != 3'b000);
      take = rsp_valid && !rsp_stall;
      rsp_text_byte = 8'h00;
      rsp_byte_valid = 1'b0;
      rsp_done_res = 1'b0;
      rsp_header_status = 1'b0;
      if (pick[SlotText0]) begin
         rsp_text_byte = text0_ff;
         rsp_byte_valid = 1'b1;
      end else if (pick[SlotText1]) begin
         rsp_text_byte = text1_ff;
         rsp_byte_valid = 1'b1;
      end else if (pick[SlotDone]) begin
         rsp_done_res = 1'b1;
         rsp_header_status = status_ff;
      end

      remaining = take ? (slots_ff & ~pick) : slots_ff;
      pop = (remaining == 3'b000) && !q_status.empty;
      slots_in = remaining;
      text0_in = text0_ff;
      text1_in = text1_ff;
      status_in = status_ff;
      if (pop) begin
         slots_in = head_data.slot_valid;
         text0_in = head_data.text0;
         text1_in = head_data.text1;
         status_in = head_data.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= 3'b000;
      end else begin
         slots_ff <= slots_in;
      end
   end

   always_ff @(posedge clock) begin
      text0_ff <= text0_in;
      text1_ff <= text1_in;
      status_ff <= status_in;
   end

endmodule
